[hdl/zone_grid_note_trigger_defines.svh]
// ---------------------------------------------------------------------------
// zone grid note trigger assertion macros
// clocked on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef ZONE_GRID_NOTE_TRIGGER_DEFINES_SVH
`define ZONE_GRID_NOTE_TRIGGER_DEFINES_SVH

// same-cycle implication
`define ZGNT_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ZGNT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/zgnt_pkg.sv]
// ---------------------------------------------------------------------------
// zgnt_pkg
// shared types and constants of the zone grid note trigger
// ---------------------------------------------------------------------------
package zgnt_pkg;

  localparam int COORD_W    = 10;
  localparam int DIST_W     = 13;
  localparam int VEL_W      = 7;
  localparam int NOTE_W     = 7;
  localparam int CHAN_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH   = 2'd0,
    REG_CELL_HEIGHT  = 2'd1,
    REG_MIDI_CHANNEL = 2'd2
  } reg_index_t;

  localparam logic [COORD_W-1:0] CELL_WIDTH_RST   = 10'd128;
  localparam logic [COORD_W-1:0] CELL_HEIGHT_RST  = 10'd120;
  localparam logic [CHAN_W-1:0]  MIDI_CHANNEL_RST = 5'd1;

  localparam logic [DIST_W-1:0] DIST_LO   = 13'd500;
  localparam logic [DIST_W-1:0] DIST_HI   = 13'd750;
  localparam logic [VEL_W-1:0]  VEL_MIN   = 7'd30;
  localparam logic [VEL_W-1:0]  VEL_MAX   = 7'd127;
  localparam logic [NOTE_W-1:0] NOTE_BASE = 7'd64;

  // depth offset above DIST_LO fits 8 bits; quotient by reciprocal
  localparam int     DIST_OFS_W  = 8;
  localparam int     VEL_SPAN    = 97;
  localparam int     DIST_SPAN   = 250;
  localparam int     RECIP_SHIFT = 24;
  localparam int     RECIP_W     = 23;
  localparam longint RECIP_VAL   =
    (longint'(VEL_SPAN) * (longint'(1) << RECIP_SHIFT) + DIST_SPAN - 1) / DIST_SPAN;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int     VEL_PROD_W  = DIST_OFS_W + RECIP_W;

  typedef struct packed {
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;
    logic              note_on;
    logic [CHAN_W-1:0] channel_out;
    logic              last_event;
  } note_t;

endpackage

[hdl/zone_grid_note_trigger.sv]
// flow: a request is written to the queue at its accepting edge and popped while the back is idle;
// a centroid is stored at its pop; an end of frame starts a scan that ends with the frame's last note
// an end of frame holds the back while it scans all GRID_COLUMNS*GRID_ROWS cells,
// one cell per cycle through the store read port unless the output stalls
// the front takes a request every cycle while the four-entry queue has room
// reset: synchronous, clears registers and entry flags; both stores read as zero at once
// ---------------------------------------------------------------------------
// zone_grid_note_trigger
// maps object centroids to grid cells and emits note on/off per frame
// ---------------------------------------------------------------------------
module zone_grid_note_trigger #(
  parameter int GRID_COLUMNS = 5,
  parameter int GRID_ROWS    = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // x position[9:0], y position[19:10], distance_mm[32:20], zero pad
  input  logic [zgnt_pkg::IN_TDATA_W-1:0]        s_tdata,
  // action
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // note_number[6:0], note_velocity[13:7], channel_out[18:14], zero pad
  output logic [zgnt_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // note_on
  output logic                                   m_tuser,
  output logic                                   m_tlast,
  input  logic                                   cfg_wen,
  input  logic [zgnt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [zgnt_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CELLS   = GRID_COLUMNS * GRID_ROWS;
  localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ENTRY_W = 1 + IDX_W + zgnt_pkg::VEL_W;

  logic [zgnt_pkg::COORD_W-1:0] cell_width;
  logic [zgnt_pkg::COORD_W-1:0] cell_height;
  logic [zgnt_pkg::CHAN_W-1:0]  midi_channel;

  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic [ENTRY_W-1:0]           q_wdata;
  logic [ENTRY_W-1:0]           q_rdata;
  zgnt_pkg::note_t              out_note;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= zgnt_pkg::CELL_WIDTH_RST;
      cell_height  <= zgnt_pkg::CELL_HEIGHT_RST;
      midi_channel <= zgnt_pkg::MIDI_CHANNEL_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        zgnt_pkg::REG_CELL_WIDTH:   cell_width   <= cfg_data;
        zgnt_pkg::REG_CELL_HEIGHT:  cell_height  <= cfg_data;
        zgnt_pkg::REG_MIDI_CHANNEL: midi_channel <= cfg_data[zgnt_pkg::CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  zgnt_front #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .IDX_W        (IDX_W)
  ) u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cell_width  (cell_width),
    .cell_height (cell_height),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  zgnt_fifo #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  zgnt_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .midi_channel (midi_channel),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_note     (out_note)
  );

  assign m_tdata = {5'b0, out_note.channel_out, out_note.note_velocity, out_note.note_number};
  assign m_tuser = out_note.note_on;
  assign m_tlast = out_note.last_event;

endmodule

[hdl/zgnt_fifo.sv]
// ---------------------------------------------------------------------------
// zgnt_fifo
// short request queue between the classify front and the scan back
// ---------------------------------------------------------------------------
module zgnt_fifo #(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0]                 mem [zgnt_pkg::QUEUE_DEPTH];
  logic [zgnt_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [zgnt_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [zgnt_pkg::QUEUE_PTR_W:0]   count;

  assign full     = (count == (zgnt_pkg::QUEUE_PTR_W + 1)'(zgnt_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/zgnt_front.sv]
// ---------------------------------------------------------------------------
// zgnt_front
// accepts requests, finds the grid cell and the depth velocity
// ---------------------------------------------------------------------------
module zgnt_front #(
  parameter int GRID_COLUMNS = 5,
  parameter int GRID_ROWS    = 4,
  parameter int IDX_W        = 5
) (
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [zgnt_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                s_tuser,
  input  logic [zgnt_pkg::COORD_W-1:0]        cell_width,
  input  logic [zgnt_pkg::COORD_W-1:0]        cell_height,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [IDX_W+zgnt_pkg::VEL_W:0]      q_data
);

  localparam int MAX_DIM = (GRID_COLUMNS > GRID_ROWS) ? GRID_COLUMNS : GRID_ROWS;
  localparam int K_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PROD_W  = zgnt_pkg::COORD_W + K_W;

  logic [zgnt_pkg::COORD_W-1:0]    pos_x;
  logic [zgnt_pkg::COORD_W-1:0]    pos_y;
  logic [zgnt_pkg::DIST_W-1:0]     distance_mm;
  logic [IDX_W-1:0]                col;
  logic [IDX_W-1:0]                row;
  logic [IDX_W-1:0]                idx;
  logic [zgnt_pkg::DIST_OFS_W-1:0] dist_ofs;
  logic [zgnt_pkg::VEL_PROD_W-1:0] vel_prod;
  logic [zgnt_pkg::VEL_W-1:0]      vel;

  assign pos_x       = s_tdata[9:0];
  assign pos_y       = s_tdata[19:10];
  assign distance_mm = s_tdata[32:20];

  // quotient saturating at the top cell: count the multiples not above the position
  always_comb begin
    col = '0;
    for (int k = 1; k < GRID_COLUMNS; k++) begin
      if (PROD_W'(pos_x) >= PROD_W'(k) * PROD_W'(cell_width)) begin
        col = col + 1'b1;
      end
    end
    row = '0;
    for (int k = 1; k < GRID_ROWS; k++) begin
      if (PROD_W'(pos_y) >= PROD_W'(k) * PROD_W'(cell_height)) begin
        row = row + 1'b1;
      end
    end
  end

  assign idx = IDX_W'(row * IDX_W'(GRID_COLUMNS)) + col;

  assign dist_ofs = zgnt_pkg::DIST_OFS_W'(distance_mm - zgnt_pkg::DIST_LO);
  assign vel_prod = zgnt_pkg::VEL_PROD_W'(dist_ofs) * zgnt_pkg::VEL_PROD_W'(zgnt_pkg::RECIP);

  always_comb begin
    if (distance_mm <= zgnt_pkg::DIST_LO) begin
      vel = zgnt_pkg::VEL_MAX - zgnt_pkg::VEL_MIN;
    end else if (distance_mm >= zgnt_pkg::DIST_HI) begin
      vel = '0;
    end else begin
      vel = zgnt_pkg::VEL_MAX - zgnt_pkg::VEL_MIN
          - vel_prod[zgnt_pkg::VEL_PROD_W-1 -: zgnt_pkg::VEL_W];
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_data   = {s_tuser, idx, vel};

endmodule

[hdl/zgnt_back.sv]
// ---------------------------------------------------------------------------
// zgnt_back
// writes cell velocities and scans the grid at end of frame
// ---------------------------------------------------------------------------
module zgnt_back #(
  parameter int GRID_COLUMNS = 5,
  parameter int GRID_ROWS    = 4,
  parameter int IDX_W        = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  logic [IDX_W+zgnt_pkg::VEL_W:0]    q_data,
  output logic                              q_pop,
  input  logic [zgnt_pkg::CHAN_W-1:0]       midi_channel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output zgnt_pkg::note_t                   out_note
);

  localparam int               CELLS = GRID_COLUMNS * GRID_ROWS;
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(CELLS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t                     state;
  logic [zgnt_pkg::VEL_W-1:0] cur_mem  [CELLS];
  logic [zgnt_pkg::VEL_W-1:0] prev_mem [CELLS];
  logic [CELLS-1:0]           cur_vld;
  logic [CELLS-1:0]           prev_vld;

  logic [IDX_W-1:0]           rd_idx;
  logic                       rd_on;
  logic                       s1_vld;
  logic [IDX_W-1:0]           s1_idx;
  logic [zgnt_pkg::VEL_W-1:0] cur_q;
  logic [zgnt_pkg::VEL_W-1:0] prev_q;
  logic                       cur_qv;
  logic                       prev_qv;
  logic                       pend_vld;
  zgnt_pkg::note_t            pend;

  logic                       q_eof;
  logic [IDX_W-1:0]           q_idx;
  logic [zgnt_pkg::VEL_W-1:0] q_vel;
  logic [zgnt_pkg::VEL_W-1:0] cur_eff;
  logic [zgnt_pkg::VEL_W-1:0] prev_eff;
  logic                       change;
  logic                       out_free;
  logic                       stall;
  logic                       issue;
  logic                       retire;
  logic                       flush_out;
  logic                       out_load;
  zgnt_pkg::note_t            new_note;
  zgnt_pkg::note_t            out_next;

  assign {q_eof, q_idx, q_vel} = q_data;

  assign cur_eff   = cur_qv ? cur_q : '0;
  assign prev_eff  = prev_qv ? prev_q : '0;
  assign change    = s1_vld && ((cur_eff == '0) != (prev_eff == '0));
  assign out_free  = !out_valid || out_ready;
  assign stall     = change && pend_vld && !out_free;
  assign issue     = (state == ST_SCAN) && rd_on && !stall;
  assign retire    = (state == ST_SCAN) && s1_vld && !stall;
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign flush_out = (state == ST_FLUSH) && pend_vld && out_free;
  assign out_load  = (retire && change && pend_vld) || flush_out;

  always_comb begin
    new_note.note_number   = zgnt_pkg::NOTE_BASE - zgnt_pkg::NOTE_W'(s1_idx);
    new_note.note_velocity = cur_eff;
    new_note.note_on       = (cur_eff != '0);
    new_note.channel_out   = midi_channel;
    new_note.last_event    = 1'b0;
  end

  // held note goes out, marked last when the scan is over
  always_comb begin
    out_next            = pend;
    out_next.last_event = flush_out;
  end

  // grid stores, registered read at the scan index
  always_ff @(posedge clk) begin
    if (q_pop && !q_eof) begin
      cur_mem[q_idx] <= q_vel;
    end
    if (retire) begin
      prev_mem[s1_idx] <= cur_eff;
    end
    if (issue) begin
      cur_q   <= cur_mem[rd_idx];
      prev_q  <= prev_mem[rd_idx];
      cur_qv  <= cur_vld[rd_idx];
      prev_qv <= prev_vld[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_vld   <= '0;
      prev_vld  <= '0;
      rd_on     <= 1'b0;
      s1_vld    <= 1'b0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_note  <= out_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_eof) begin
              state    <= ST_SCAN;
              rd_idx   <= '0;
              rd_on    <= 1'b1;
              pend_vld <= 1'b0;
            end else begin
              cur_vld[q_idx] <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cur_vld[rd_idx] <= 1'b0;
            s1_vld          <= 1'b1;
            s1_idx          <= rd_idx;
            if (rd_idx == LAST) begin
              rd_on <= 1'b0;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end else if (!stall) begin
            s1_vld <= 1'b0;
          end
          if (retire) begin
            prev_vld[s1_idx] <= 1'b1;
            if (change) begin
              pend     <= new_note;
              pend_vld <= 1'b1;
            end
            if (s1_idx == LAST) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_vld) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_vld <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/zgnt_checker.sv]
// ---------------------------------------------------------------------------
// zgnt_checker
// port-level checks on the note stream of the zone grid note trigger
// ---------------------------------------------------------------------------
`include "zone_grid_note_trigger_defines.svh"

module zgnt_checker #(
  parameter int GRID_COLUMNS = 5,
  parameter int GRID_ROWS    = 4
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [zgnt_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast
);

  localparam logic [zgnt_pkg::NOTE_W-1:0] NOTE_LOW =
    zgnt_pkg::NOTE_W'(64 - GRID_COLUMNS * GRID_ROWS + 1);

  `ZGNT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "note request changed while stalled")
  `ZGNT_ASSERT(a_note_range, m_tvalid, (m_tdata[6:0] <= zgnt_pkg::NOTE_BASE) && (m_tdata[6:0] >= NOTE_LOW), "note number outside the grid")
  `ZGNT_ASSERT(a_off_vel, m_tvalid && !m_tuser, m_tdata[13:7] == 7'd0, "note-off with nonzero velocity")
  `ZGNT_ASSERT(a_on_vel, m_tvalid && m_tuser, m_tdata[13:7] != 7'd0, "note-on with zero velocity")

endmodule

bind zone_grid_note_trigger zgnt_checker #(
  .GRID_COLUMNS (GRID_COLUMNS),
  .GRID_ROWS    (GRID_ROWS)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[sim/zone_grid_note_trigger_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// zone_grid_note_trigger_tb
// streams centroid and end-of-frame requests through the grid note trigger
// and checks every note event against a cycle-free model of the cell stores;
// directed table first, then random frames with bursty input and
// a stalling note receiver
// ---------------------------------------------------------------------------
module zone_grid_note_trigger_tb;

  localparam int GRID_COLUMNS  = 5;
  localparam int GRID_ROWS     = 4;
  localparam int CELL_COUNT    = GRID_COLUMNS * GRID_ROWS;
  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic ACT_CENTROID  = 1'b0;
  localparam logic ACT_FRAME_END = 1'b1;

  // index past the register list, writes to it are dropped
  localparam logic [zgnt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [2:0] {
    ROW_CFG,
    ROW_CENTROID,
    ROW_FRAME_PRED,
    ROW_FRAME_NONE,
    ROW_FRAME_ONE
  } row_kind_t;

  typedef struct {
    row_kind_t                           kind;
    logic [zgnt_pkg::CFG_IDX_W-1:0]      idx;
    logic [zgnt_pkg::CFG_DATA_W-1:0]     data;
    logic [zgnt_pkg::COORD_W-1:0]        x;
    logic [zgnt_pkg::COORD_W-1:0]        y;
    logic [zgnt_pkg::DIST_W-1:0]         depth;
    zgnt_pkg::note_t                     note;
  } stim_row_t;

  localparam zgnt_pkg::note_t NO_NOTE = '0;
  localparam int DIRECTED_ROWS = 26;

  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{ROW_FRAME_NONE, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_FRAME_ONE, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0,
      '{7'd64, 7'd97, 1'b1, 5'd1, 1'b1}},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd1023, 10'd1023, 13'd8191, NO_NOTE},
    '{ROW_FRAME_ONE, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0,
      '{7'd64, 7'd0, 1'b0, 5'd1, 1'b1}},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd130, 10'd0, 13'd500, NO_NOTE},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd130, 10'd0, 13'd749, NO_NOTE},
    '{ROW_FRAME_ONE, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0,
      '{7'd63, 7'd1, 1'b1, 5'd1, 1'b1}},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd130, 10'd0, 13'd600, NO_NOTE},
    '{ROW_FRAME_NONE, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_CELL_WIDTH, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_CELL_HEIGHT, 10'd1023, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_MIDI_CHANNEL, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, REG_SPARE, 10'd1023, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd5, 10'd1023, 13'd501, NO_NOTE},
    '{ROW_FRAME_PRED, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_CELL_WIDTH, 10'd1, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_CELL_HEIGHT, 10'd1, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_MIDI_CHANNEL, 10'd31, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd3, 10'd2, 13'd750, NO_NOTE},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd1, 10'd1, 13'd650, NO_NOTE},
    '{ROW_FRAME_PRED, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_CELL_WIDTH, 10'd1023, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CFG, zgnt_pkg::REG_MIDI_CHANNEL, 10'd16, 10'd0, 10'd0, 13'd0, NO_NOTE},
    '{ROW_CENTROID, REG_SPARE, 10'd0, 10'd682, 10'd300, 13'd8191, NO_NOTE},
    '{ROW_FRAME_PRED, REG_SPARE, 10'd0, 10'd0, 10'd0, 13'd0, NO_NOTE}
  };

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [zgnt_pkg::IN_TDATA_W-1:0]     s_tdata;
  logic                                s_tuser;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [zgnt_pkg::OUT_TDATA_W-1:0]    m_tdata;
  logic                                m_tuser;
  logic                                m_tlast;
  logic                                cfg_wen;
  logic [zgnt_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [zgnt_pkg::CFG_DATA_W-1:0]     cfg_data;

  // model of the block's registers and cell stores
  logic [zgnt_pkg::COORD_W-1:0] cell_w;
  logic [zgnt_pkg::COORD_W-1:0] cell_h;
  logic [zgnt_pkg::CHAN_W-1:0]  chan;
  logic [zgnt_pkg::VEL_W-1:0]   cur_vel  [CELL_COUNT];
  logic [zgnt_pkg::VEL_W-1:0]   prev_vel [CELL_COUNT];

  zgnt_pkg::note_t scan_notes[$];
  zgnt_pkg::note_t pending_notes[$];

  int error_count = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  logic [15:0] rx_tick = '0;

  zone_grid_note_trigger #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int cell_coord(logic [zgnt_pkg::COORD_W-1:0] pos,
                                    logic [zgnt_pkg::COORD_W-1:0] size, int count);
    int q;
    if (size == 0) return count - 1;
    q = int'(pos) / int'(size);
    if (q > count - 1) q = count - 1;
    return q;
  endfunction

  function automatic logic [zgnt_pkg::VEL_W-1:0] depth_to_velocity(
    logic [zgnt_pkg::DIST_W-1:0] d);
    int m;
    if (d <= zgnt_pkg::DIST_LO) m = int'(zgnt_pkg::VEL_MIN);
    else if (d >= zgnt_pkg::DIST_HI) m = int'(zgnt_pkg::VEL_MAX);
    else m = int'(zgnt_pkg::VEL_MIN)
           + ((int'(d) - int'(zgnt_pkg::DIST_LO)) * zgnt_pkg::VEL_SPAN) / zgnt_pkg::DIST_SPAN;
    return zgnt_pkg::VEL_MAX - zgnt_pkg::VEL_W'(m);
  endfunction

  // advance the model by one request; notes of a frame end land in scan_notes
  function automatic void track_request(logic act, logic [zgnt_pkg::COORD_W-1:0] x,
                                        logic [zgnt_pkg::COORD_W-1:0] y,
                                        logic [zgnt_pkg::DIST_W-1:0] d);
    int              cell_idx;
    zgnt_pkg::note_t n;
    scan_notes.delete();
    if (act == ACT_CENTROID) begin
      cell_idx = cell_coord(y, cell_h, GRID_ROWS) * GRID_COLUMNS
               + cell_coord(x, cell_w, GRID_COLUMNS);
      cur_vel[cell_idx] = depth_to_velocity(d);
    end else begin
      for (int i = 0; i < CELL_COUNT; i++) begin
        n.note_number = zgnt_pkg::NOTE_BASE - zgnt_pkg::NOTE_W'(i);
        n.channel_out = chan;
        n.last_event  = 1'b0;
        if (prev_vel[i] == 0 && cur_vel[i] != 0) begin
          n.note_velocity = cur_vel[i];
          n.note_on       = 1'b1;
          scan_notes.push_back(n);
        end else if (prev_vel[i] != 0 && cur_vel[i] == 0) begin
          n.note_velocity = '0;
          n.note_on       = 1'b0;
          scan_notes.push_back(n);
        end
      end
      if (scan_notes.size() > 0) scan_notes[scan_notes.size()-1].last_event = 1'b1;
      for (int i = 0; i < CELL_COUNT; i++) begin
        prev_vel[i] = cur_vel[i];
        cur_vel[i]  = '0;
      end
    end
  endfunction

  task automatic send_request(input logic act, input logic [zgnt_pkg::COORD_W-1:0] x,
                              input logic [zgnt_pkg::COORD_W-1:0] y,
                              input logic [zgnt_pkg::DIST_W-1:0] d,
                              input bit queue_notes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 5);
      if (gap != 0) begin
        if (s_tvalid) s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= zgnt_pkg::IN_TDATA_W'({d, y, x});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_request(act, x, y, d);
    if (queue_notes) foreach (scan_notes[i]) pending_notes.push_back(scan_notes[i]);
  endtask

  // wait until every note is out and the block has drained its queue
  task automatic settle_block();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [zgnt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [zgnt_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    case (idx)
      zgnt_pkg::REG_CELL_WIDTH:   cell_w = val;
      zgnt_pkg::REG_CELL_HEIGHT:  cell_h = val;
      zgnt_pkg::REG_MIDI_CHANNEL: chan   = val[zgnt_pkg::CHAN_W-1:0];
      default: ;
    endcase
  endtask

  // receiver stall pattern, cycling through four modes
  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    case (rx_tick[10:9])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= ((rx_tick % 16'd5) < 16'd2);
      default: m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    zgnt_pkg::note_t got;
    zgnt_pkg::note_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.note_number   = m_tdata[6:0];
      got.note_velocity = m_tdata[13:7];
      got.channel_out   = m_tdata[18:14];
      got.note_on       = m_tuser;
      got.last_event    = m_tlast;
      if (pending_notes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected note: expected none, got num=%0d vel=%0d on=%0d",
                 $time, got.note_number, got.note_velocity, got.note_on,
                 " ch=%0d last=%0d", got.channel_out, got.last_event);
      end else begin
        want = pending_notes.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t: note mismatch: expected num=%0d vel=%0d on=%0d ch=%0d last=%0d",
                   $time, want.note_number, want.note_velocity, want.note_on,
                   want.channel_out, want.last_event,
                   ", got num=%0d vel=%0d on=%0d ch=%0d last=%0d",
                   got.note_number, got.note_velocity, got.note_on, got.channel_out,
                   got.last_event);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int random_items;
    int phase;
    int n_cents;
    logic [zgnt_pkg::DIST_W-1:0] d;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cell_w    = zgnt_pkg::CELL_WIDTH_RST;
    cell_h    = zgnt_pkg::CELL_HEIGHT_RST;
    chan      = zgnt_pkg::MIDI_CHANNEL_RST;
    for (int i = 0; i < CELL_COUNT; i++) begin
      cur_vel[i]  = '0;
      prev_vel[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_CFG: begin
          settle_block();
          write_reg(directed_rows[r].idx, directed_rows[r].data);
        end
        ROW_CENTROID:
          send_request(ACT_CENTROID, directed_rows[r].x, directed_rows[r].y,
                       directed_rows[r].depth, 1'b1);
        ROW_FRAME_PRED: send_request(ACT_FRAME_END, '0, '0, '0, 1'b1);
        ROW_FRAME_NONE: send_request(ACT_FRAME_END, '0, '0, '0, 1'b0);
        ROW_FRAME_ONE: begin
          send_request(ACT_FRAME_END, '0, '0, '0, 1'b0);
          pending_notes.push_back(directed_rows[r].note);
        end
        default: ;
      endcase
    end

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle_block();
      if (phase == 2) begin
        // every cell lit in one frame, then all released
        write_reg(zgnt_pkg::REG_CELL_WIDTH, 10'd1);
        write_reg(zgnt_pkg::REG_CELL_HEIGHT, 10'd1);
        for (int r = 0; r < GRID_ROWS; r++)
          for (int c = 0; c < GRID_COLUMNS; c++)
            send_request(ACT_CENTROID, zgnt_pkg::COORD_W'(c), zgnt_pkg::COORD_W'(r),
                         zgnt_pkg::DIST_W'($urandom_range(500, 749)), 1'b1);
        send_request(ACT_FRAME_END, '0, '0, '0, 1'b1);
        send_request(ACT_FRAME_END, '0, '0, '0, 1'b1);
        random_items += CELL_COUNT + 2;
        settle_block();
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0: write_reg(zgnt_pkg::REG_CELL_WIDTH, 10'd0);
          1: write_reg(zgnt_pkg::REG_CELL_WIDTH, 10'd1);
          2: write_reg(zgnt_pkg::REG_CELL_WIDTH, 10'd1023);
          default: write_reg(zgnt_pkg::REG_CELL_WIDTH,
                             zgnt_pkg::CFG_DATA_W'($urandom_range(100, 300)));
        endcase
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0: write_reg(zgnt_pkg::REG_CELL_HEIGHT, 10'd0);
          1: write_reg(zgnt_pkg::REG_CELL_HEIGHT, 10'd1);
          2: write_reg(zgnt_pkg::REG_CELL_HEIGHT, 10'd1023);
          default: write_reg(zgnt_pkg::REG_CELL_HEIGHT,
                             zgnt_pkg::CFG_DATA_W'($urandom_range(100, 360)));
        endcase
      end
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 9) == 0)
          write_reg(zgnt_pkg::REG_MIDI_CHANNEL, zgnt_pkg::CFG_DATA_W'($urandom_range(0, 31)));
        else
          write_reg(zgnt_pkg::REG_MIDI_CHANNEL, zgnt_pkg::CFG_DATA_W'($urandom_range(1, 16)));
      end
      repeat ($urandom_range(2, 6)) begin
        n_cents = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
        repeat (n_cents) begin
          if ($urandom_range(0, 9) < 7) d = zgnt_pkg::DIST_W'($urandom_range(480, 770));
          else d = zgnt_pkg::DIST_W'($urandom_range(0, 8191));
          send_request(ACT_CENTROID, zgnt_pkg::COORD_W'($urandom_range(0, 1023)),
                       zgnt_pkg::COORD_W'($urandom_range(0, 1023)), d, 1'b1);
        end
        send_request(ACT_FRAME_END, zgnt_pkg::COORD_W'($urandom_range(0, 1023)),
                     zgnt_pkg::COORD_W'($urandom_range(0, 1023)),
                     zgnt_pkg::DIST_W'($urandom_range(0, 8191)), 1'b1);
        random_items += n_cents + 1;
      end
      phase++;
    end

    settle_block();
    if (error_count == 0 && pending_notes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/zgnt_pkg.sv
hdl/zgnt_fifo.sv
hdl/zgnt_front.sv
hdl/zgnt_back.sv
hdl/zone_grid_note_trigger.sv
hdl/zgnt_checker.sv
sim/zone_grid_note_trigger_tb.sv
